// ===== sv/gscs_pkg.sv =====
// gscs_pkg: shared widths, codes, entry and divider request types
// for the gas sensor calibrate-and-score block. No dependencies.
package gscs_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int CAL_SAMPLES_DEF  = 50;

  localparam int CH_W      = 2;
  localparam int ADC_W     = 10;
  localparam int RATIO_W   = 16;
  localparam int MASK_W    = 4;
  localparam int ACC_W     = 38;
  localparam int CNT_W     = 6;
  localparam int BASE_W    = 32;
  localparam int RS_W      = 32;
  localparam int SCORE_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = 56;
  localparam int DEN_W     = 64;
  localparam int NB_W      = 6;

  localparam int RATIO_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] IDX_MASK = 3'd4;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CALIB   = 1'b1;

  localparam logic [STATUS_W-1:0] LVL_CLEAN    = 2'd0;
  localparam logic [STATUS_W-1:0] LVL_MODERATE = 2'd1;
  localparam logic [STATUS_W-1:0] LVL_HIGH     = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd2560;
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 16'd256;
  localparam logic [RATIO_W-1:0] RATIO_FLOOR = 16'd259;
  localparam logic [ADC_W-1:0]   ADC_FULL    = 10'd1023;
  localparam logic [RS_W-1:0]    RS_AT_FULL  = 32'd66;
  localparam logic [RS_W-1:0]    RS_MAX      = 32'hFFFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = 7'd100;
  localparam logic [SCORE_W-1:0] SCORE_MOD   = 7'd33;
  localparam logic [SCORE_W-1:0] SCORE_HIGH  = 7'd66;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [CNT_W-1:0]  cnt;
    logic [BASE_W-1:0] base;
  } gscs_entry_t;

  localparam gscs_entry_t ENTRY_RESET = '{acc: '0, cnt: '0, base: 32'h0001_0000};

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [NB_W-1:0]  nbits;
  } gscs_div_req_t;

endpackage

// ===== sv/gscs_if.sv =====
// gscs channel interfaces: sample request, result and register write
// depends on gscs_pkg for field widths
interface gscs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [gscs_pkg::CH_W-1:0]      channel;
  logic [gscs_pkg::ADC_W-1:0]     adc_sample;
  modport source (output valid, req_type, channel, adc_sample, input ready);
  modport sink (input valid, req_type, channel, adc_sample, output ready);
endinterface

interface gscs_out_if;
  logic                           valid;
  logic                           ready;
  logic [gscs_pkg::SCORE_W-1:0]   score;
  logic [gscs_pkg::STATUS_W-1:0]  status;
  logic                           calibration_done;
  logic                           channel_active;
  modport source (output valid, score, status, calibration_done, channel_active,
                  input ready);
  modport sink (input valid, score, status, calibration_done, channel_active,
                output ready);
endinterface

interface gscs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gscs_pkg::CFG_IDX_W-1:0] index;
  logic [gscs_pkg::RATIO_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/gscs_div.sv =====
// gscs_div: shared shift-subtract divider, one quotient bit per cycle
// caller pre-aligns the divisor; depends on gscs_pkg
module gscs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gscs_pkg::gscs_div_req_t      req,
  output logic                         busy,
  output logic                         done,
  output logic [gscs_pkg::NUM_W-1:0]   quo
);
  logic [gscs_pkg::NUM_W-1:0] rem_r;
  logic [gscs_pkg::DEN_W-1:0] d_r;
  logic [gscs_pkg::NUM_W-1:0] q_r;
  logic [gscs_pkg::NB_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       ge;

  assign ge   = {{(gscs_pkg::DEN_W-gscs_pkg::NUM_W){1'b0}}, rem_r} >= d_r;
  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= req.num;
        d_r    <= req.den;
        q_r    <= '0;
        cnt_r  <= req.nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - d_r[gscs_pkg::NUM_W-1:0];
        end
        q_r   <= {q_r[gscs_pkg::NUM_W-2:0], ge};
        d_r   <= d_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == gscs_pkg::NB_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/gscs_mem.sv =====
// gscs_mem: per-channel state memory (accumulator, count, baseline)
// registered read, valid bits give reset contents; uses gscs_pkg
module gscs_mem #(
  parameter int DEPTH = gscs_pkg::NUM_CHANNELS_DEF,
  parameter int AW    = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  gscs_pkg::gscs_entry_t wr_data,
  output gscs_pkg::gscs_entry_t rd_data
);
  gscs_pkg::gscs_entry_t mem [DEPTH];
  gscs_pkg::gscs_entry_t rd_ent_r;
  logic [DEPTH-1:0]      vld_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_ent_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_ent_r : gscs_pkg::ENTRY_RESET;
endmodule

// ===== sv/gas_sensor_calibrate_and_score.sv =====
// gas_sensor_calibrate_and_score: top level sequencer over the state memory
// and the shared divider; uses gscs_pkg, gscs_if, gscs_mem, gscs_div
// one request at a time; a measurement runs the rs divide and, when needed, the
// score divide, a calibration the rs divide, and the completing calibration also
// the average multiply and the baseline divide; zero or full-scale samples skip
// the rs divide, and inactive channels go straight to the output
// result sits in an output register; next request accepted the cycle after it loads
// synchronous reset: ratios 10.0, mask 0, channel state reads as reset values
module gas_sensor_calibrate_and_score #(
  parameter int NUM_CHANNELS        = gscs_pkg::NUM_CHANNELS_DEF,
  parameter int CALIBRATION_SAMPLES = gscs_pkg::CAL_SAMPLES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  gscs_in_if.sink     in_req,
  gscs_out_if.source  out_res,
  gscs_cfg_if.sink    cfg_wr
);
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int AVG_SH = gscs_pkg::ACC_W + 6;
  localparam int RCP_W  = AVG_SH + 1;
  localparam int NA_W   = gscs_pkg::ACC_W / 2;
  localparam int MB_W   = (RCP_W + 1) / 2;
  localparam int PP_W   = NA_W + MB_W;
  localparam int PROD_W = gscs_pkg::ACC_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RECIP = RCP_W'(((64'd1 << AVG_SH)
    + 64'(CALIBRATION_SAMPLES - 1)) / 64'(CALIBRATION_SAMPLES));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RS   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_BASE = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_NUM  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_SC   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_BDIV = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic [gscs_pkg::RATIO_W-1:0] ratio_r [gscs_pkg::RATIO_REGS];
  logic [gscs_pkg::MASK_W-1:0]  mask_r;

  logic                          req_r;
  logic [gscs_pkg::CH_W-1:0]     ch_r;
  logic [gscs_pkg::ADC_W-1:0]    adc_r;
  logic [gscs_pkg::RS_W-1:0]     rs_r;
  logic [47:0]                   lhs_r;
  logic [47:0]                   den_r;
  logic [39:0]                   rhs_r;
  logic [54:0]                   num_r;
  logic [gscs_pkg::SCORE_W-1:0]  score_r;
  logic                          cdone_r;
  logic                          act_r;
  logic [gscs_pkg::ACC_W-1:0]    avg_n_r;
  logic [PROD_W-1:0]             prod_r;
  logic [1:0]                    mstep_r;

  logic                          out_valid_r;
  logic [gscs_pkg::SCORE_W-1:0]  out_score_r;
  logic [gscs_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_cdone_r;
  logic                          out_act_r;

  logic                          accept;
  logic                          active;
  logic                          adc_edge;
  gscs_pkg::gscs_entry_t         ent;
  gscs_pkg::gscs_entry_t         wr_ent;
  logic                          wr_en;
  logic [gscs_pkg::ACC_W-1:0]    acc_new;
  logic [gscs_pkg::CNT_W-1:0]    cnt_new;
  logic                          complete;
  logic [gscs_pkg::RATIO_W-1:0]  ratio;
  logic [31:0]                   avg;
  logic [gscs_pkg::RS_W-1:0]     rs_now;
  logic                          rs_ready;
  logic [47:0]                   diff;
  logic [gscs_pkg::STATUS_W-1:0] status_of;
  logic [NA_W-1:0]               mul_a;
  logic [MB_W-1:0]               mul_b;
  logic [PP_W-1:0]               pp;
  logic [PROD_W-1:0]             pp_sh;

  gscs_pkg::gscs_div_req_t       div_req;
  logic                          div_busy;
  logic                          div_done;
  logic [gscs_pkg::NUM_W-1:0]    div_quo;

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign active       = (int'(in_req.channel) < NUM_CHANNELS) && mask_r[in_req.channel];
  assign adc_edge     = (in_req.adc_sample == '0) || (in_req.adc_sample == gscs_pkg::ADC_FULL);
  assign ratio        = ratio_r[ch_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gscs_pkg::RATIO_REGS; i++) begin
        ratio_r[i] <= gscs_pkg::RATIO_RESET;
      end
      mask_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      if (int'(cfg_wr.index) < gscs_pkg::RATIO_REGS) begin
        ratio_r[cfg_wr.index[gscs_pkg::CH_W-1:0]] <=
          (cfg_wr.data <= gscs_pkg::RATIO_ONE) ? gscs_pkg::RATIO_FLOOR : cfg_wr.data;
      end else if (cfg_wr.index == gscs_pkg::IDX_MASK) begin
        mask_r <= cfg_wr.data[gscs_pkg::MASK_W-1:0];
      end
    end
  end

  gscs_mem #(.DEPTH(NUM_CHANNELS), .AW(AW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (AW'(in_req.channel)),
    .wr_en   (wr_en),
    .wr_addr (AW'(ch_r)),
    .wr_data (wr_ent),
    .rd_data (ent)
  );

  gscs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign acc_new  = ent.acc + gscs_pkg::ACC_W'(rs_r);
  assign cnt_new  = ent.cnt + 1'b1;
  assign complete = cnt_new >= gscs_pkg::CNT_W'(CALIBRATION_SAMPLES);
  assign avg      = (prod_r[PROD_W-1:AVG_SH+32] != '0) ? 32'hFFFF_FFFF
                                                        : prod_r[AVG_SH+31:AVG_SH];
  assign diff     = lhs_r - 48'(rhs_r);

  // average by reciprocal multiply, one partial product per cycle
  assign mul_a = mstep_r[1] ? avg_n_r[gscs_pkg::ACC_W-1:NA_W] : avg_n_r[NA_W-1:0];
  assign mul_b = mstep_r[0] ? MB_W'(AVG_RECIP[RCP_W-1:MB_W]) : AVG_RECIP[MB_W-1:0];
  assign pp    = PP_W'(mul_a) * PP_W'(mul_b);

  always_comb begin
    case (mstep_r)
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << MB_W;
      2'd2:    pp_sh = PROD_W'(pp) << NA_W;
      default: pp_sh = PROD_W'(pp) << (NA_W + MB_W);
    endcase
  end

  always_comb begin
    if (adc_r == '0) begin
      rs_now   = gscs_pkg::RS_MAX;
      rs_ready = 1'b1;
    end else if (adc_r == gscs_pkg::ADC_FULL) begin
      rs_now   = gscs_pkg::RS_AT_FULL;
      rs_ready = 1'b1;
    end else begin
      rs_now   = div_quo[gscs_pkg::RS_W-1:0];
      rs_ready = div_done;
    end
  end

  always_comb begin
    if (score_r < gscs_pkg::SCORE_MOD) begin
      status_of = gscs_pkg::LVL_CLEAN;
    end else if (score_r < gscs_pkg::SCORE_HIGH) begin
      status_of = gscs_pkg::LVL_MODERATE;
    end else begin
      status_of = gscs_pkg::LVL_HIGH;
    end
  end

  always_comb begin
    div_req = '0;
    wr_en   = 1'b0;
    wr_ent  = ent;
    case (state_r)
      S_IDLE: begin
        if (accept && active && !adc_edge) begin
          div_req.start = 1'b1;
          div_req.num   = gscs_pkg::NUM_W'(
            {gscs_pkg::ADC_FULL - in_req.adc_sample, 16'h0000});
          div_req.den   = gscs_pkg::DEN_W'(in_req.adc_sample) << 25;
          div_req.nbits = gscs_pkg::NB_W'(26);
        end
      end
      S_ACC: begin
        if (!complete) begin
          wr_en      = 1'b1;
          wr_ent.acc = acc_new;
          wr_ent.cnt = cnt_new;
        end
      end
      S_BDIV: begin
        div_req.start = 1'b1;
        div_req.num   = gscs_pkg::NUM_W'({avg, 8'h00});
        div_req.den   = gscs_pkg::DEN_W'(ratio) << 39;
        div_req.nbits = gscs_pkg::NB_W'(40);
      end
      S_BASE: begin
        if (div_done) begin
          wr_en       = 1'b1;
          wr_ent.acc  = '0;
          wr_ent.cnt  = '0;
          wr_ent.base = (div_quo[gscs_pkg::NUM_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                             : div_quo[31:0];
        end
      end
      S_CHK: begin
        if (num_r < (55'(den_r) << 7)) begin
          div_req.start = 1'b1;
          div_req.num   = gscs_pkg::NUM_W'(num_r);
          div_req.den   = gscs_pkg::DEN_W'(den_r) << 6;
          div_req.nbits = gscs_pkg::NB_W'(7);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = active ? S_RS : S_OUT;
      S_RS:   if (rs_ready) state_nxt = (req_r == gscs_pkg::REQ_CALIB) ? S_ACC : S_MUL;
      S_ACC:  state_nxt = complete ? S_AVG : S_OUT;
      S_AVG:  if (mstep_r == 2'd3) state_nxt = S_BDIV;
      S_BDIV: state_nxt = S_BASE;
      S_BASE: if (div_done) state_nxt = S_OUT;
      S_MUL:  state_nxt = S_NUM;
      S_NUM:  state_nxt = ((ent.base == '0) || (lhs_r <= 48'(rhs_r))) ? S_OUT : S_CHK;
      S_CHK:  state_nxt = (num_r < (55'(den_r) << 7)) ? S_SC : S_OUT;
      S_SC:   if (div_done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_res.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!out_valid_r || out_res.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_r   <= in_req.req_type;
          ch_r    <= in_req.channel;
          adc_r   <= in_req.adc_sample;
          score_r <= '0;
          cdone_r <= 1'b0;
          act_r   <= active;
        end
      end
      S_RS: begin
        if (rs_ready) begin
          rs_r <= rs_now;
        end
      end
      S_ACC: begin
        if (complete) begin
          avg_n_r <= acc_new;
          prod_r  <= '0;
          mstep_r <= '0;
        end
      end
      S_AVG: begin
        prod_r  <= prod_r + pp_sh;
        mstep_r <= mstep_r + 1'b1;
      end
      S_BASE: begin
        if (div_done) begin
          cdone_r <= 1'b1;
        end
      end
      S_MUL: begin
        lhs_r <= 48'(ratio) * 48'(ent.base);
        den_r <= 48'(ratio - gscs_pkg::RATIO_ONE) * 48'(ent.base);
        rhs_r <= {rs_r, 8'h00};
      end
      S_NUM: begin
        num_r <= 55'(diff) * 55'(100);
      end
      S_CHK: begin
        if (!(num_r < (55'(den_r) << 7))) begin
          score_r <= gscs_pkg::SCORE_MAX;
        end
      end
      S_SC: begin
        if (div_done) begin
          score_r <= (div_quo[gscs_pkg::SCORE_W-1:0] > gscs_pkg::SCORE_MAX)
                     ? gscs_pkg::SCORE_MAX : div_quo[gscs_pkg::SCORE_W-1:0];
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_score_r  <= score_r;
          out_status_r <= status_of;
          out_cdone_r  <= cdone_r;
          out_act_r    <= act_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.score            = out_score_r;
  assign out_res.status           = out_status_r;
  assign out_res.calibration_done = out_cdone_r;
  assign out_res.channel_active   = out_act_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.score <= gscs_pkg::SCORE_MAX)
    else $error("score above 100");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.calibration_done |->
      out_res.channel_active && out_res.score == '0)
    else $error("calibration result with score or inactive channel");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.channel_active |->
      out_res.score == '0 && out_res.status == gscs_pkg::LVL_CLEAN)
    else $error("inactive channel with nonzero result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |->
      (out_res.status == gscs_pkg::LVL_CLEAN) == (out_res.score < gscs_pkg::SCORE_MOD))
    else $error("status does not follow score");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");
endmodule

// ===== sim/gas_sensor_calibrate_and_score_tb.sv =====
// testbench for gas_sensor_calibrate_and_score: drives sample requests and
// register writes, predicts score, status and calibration flags per request
// depends on gscs_pkg, gscs_if and the block's rtl
module gas_sensor_calibrate_and_score_tb;

  typedef struct packed {
    logic                             req_type;
    logic [gscs_pkg::CH_W-1:0]        channel;
    logic [gscs_pkg::ADC_W-1:0]       adc_sample;
  } sample_t;

  typedef struct packed {
    logic [gscs_pkg::SCORE_W-1:0]     score;
    logic [gscs_pkg::STATUS_W-1:0]    status;
    logic                             calibration_done;
    logic                             channel_active;
  } result_t;

  logic clk;
  logic rst_n;

  gscs_in_if  in_req();
  gscs_out_if out_res();
  gscs_cfg_if cfg_wr();

  gas_sensor_calibrate_and_score dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res), .cfg_wr(cfg_wr)
  );

  sample_t pending_samples[$];
  result_t expected_results[$];
  int      error_count;
  int      result_count;
  int      calib_done_count;
  int      sample_count;
  logic    in_fire;

  logic [gscs_pkg::RATIO_W-1:0] ratio_m[gscs_pkg::RATIO_REGS];
  logic [gscs_pkg::MASK_W-1:0]  mask_m;
  logic [gscs_pkg::ACC_W-1:0]   acc_m[gscs_pkg::NUM_CHANNELS_DEF];
  logic [gscs_pkg::CNT_W-1:0]   cnt_m[gscs_pkg::NUM_CHANNELS_DEF];
  logic [gscs_pkg::BASE_W-1:0]  base_m[gscs_pkg::NUM_CHANNELS_DEF];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [gscs_pkg::RS_W-1:0] resistance_of(
      logic [gscs_pkg::ADC_W-1:0] adc);
    logic [63:0] n;
    if (adc == '0) return gscs_pkg::RS_MAX;
    if (adc == gscs_pkg::ADC_FULL) return gscs_pkg::RS_AT_FULL;
    n = 64'(gscs_pkg::ADC_FULL - adc) << 16;
    return gscs_pkg::RS_W'(n / 64'(adc));
  endfunction

  function automatic logic [gscs_pkg::SCORE_W-1:0] score_from(
      logic [gscs_pkg::RS_W-1:0] rs, logic [gscs_pkg::BASE_W-1:0] base,
      logic [gscs_pkg::RATIO_W-1:0] ratio);
    logic [63:0] lhs, rhs, q;
    if (base == '0) return '0;
    lhs = 64'(ratio) * 64'(base);
    rhs = 64'(rs) << 8;
    if (lhs <= rhs) return '0;
    q = ((lhs - rhs) * 64'd100) / (64'(ratio - gscs_pkg::RATIO_ONE) * 64'(base));
    return (q > 64'd100) ? gscs_pkg::SCORE_MAX : gscs_pkg::SCORE_W'(q);
  endfunction

  function automatic result_t predict_sample(sample_t s);
    result_t r;
    logic [gscs_pkg::RS_W-1:0] rs;
    logic [63:0] avg, b;
    r = '0;
    if (!mask_m[s.channel]) return r;
    rs = resistance_of(s.adc_sample);
    r.channel_active = 1'b1;
    if (s.req_type == gscs_pkg::REQ_CALIB) begin
      acc_m[s.channel] = acc_m[s.channel] + gscs_pkg::ACC_W'(rs);
      cnt_m[s.channel] = cnt_m[s.channel] + 1'b1;
      if (cnt_m[s.channel] >= gscs_pkg::CNT_W'(gscs_pkg::CAL_SAMPLES_DEF)) begin
        avg = 64'(acc_m[s.channel]) / 64'(gscs_pkg::CAL_SAMPLES_DEF);
        if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
        b = (avg << 8) / 64'(ratio_m[s.channel]);
        if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
        base_m[s.channel] = gscs_pkg::BASE_W'(b);
        acc_m[s.channel] = '0;
        cnt_m[s.channel] = '0;
        r.calibration_done = 1'b1;
      end
    end else begin
      r.score = score_from(rs, base_m[s.channel], ratio_m[s.channel]);
      r.status = (r.score < gscs_pkg::SCORE_MOD) ? gscs_pkg::LVL_CLEAN :
                 (r.score < gscs_pkg::SCORE_HIGH) ? gscs_pkg::LVL_MODERATE :
                 gscs_pkg::LVL_HIGH;
    end
    return r;
  endfunction

  // driver
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_gap <= $urandom_range(0, 8);
    end else if (in_req.valid && !in_fire) begin
      in_req.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_req.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_samples.size() > 0) begin
      in_req.valid      <= 1'b1;
      in_req.req_type   <= pending_samples[0].req_type;
      in_req.channel    <= pending_samples[0].channel;
      in_req.adc_sample <= pending_samples[0].adc_sample;
      void'(pending_samples.pop_front());
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  // predictor at acceptance
  always @(posedge clk) begin
    sample_t s;
    in_fire <= rst_n && in_req.valid && in_req.ready;
    if (rst_n && in_req.valid && in_req.ready) begin
      s = '{in_req.req_type, in_req.channel, in_req.adc_sample};
      expected_results.push_back(predict_sample(s));
      sample_count++;
    end
  end

  // sink stalls
  int out_stall;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_res.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (out_res.valid && out_res.ready) begin
      out_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_res.ready <= 1'b1;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_res.calibration_done) calib_done_count++;
        if (out_res.score !== e.score) begin
          $error("score expected %0d got %0d", e.score, out_res.score);
          error_count++;
        end
        if (out_res.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_res.status);
          error_count++;
        end
        if (out_res.calibration_done !== e.calibration_done) begin
          $error("calibration_done expected %0d got %0d", e.calibration_done,
                 out_res.calibration_done);
          error_count++;
        end
        if (out_res.channel_active !== e.channel_active) begin
          $error("channel_active expected %0d got %0d", e.channel_active,
                 out_res.channel_active);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [gscs_pkg::CFG_IDX_W-1:0] idx,
      logic [gscs_pkg::RATIO_W-1:0] val);
    logic [gscs_pkg::RATIO_W-1:0] v;
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    if (idx < gscs_pkg::RATIO_REGS) begin
      v = (val <= gscs_pkg::RATIO_ONE) ? gscs_pkg::RATIO_FLOOR : val;
      ratio_m[idx] = v;
    end else if (idx == gscs_pkg::IDX_MASK) begin
      mask_m = val[gscs_pkg::MASK_W-1:0];
    end
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [gscs_pkg::ADC_W-1:0] rand_adc();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return gscs_pkg::ADC_FULL;
      2: return gscs_pkg::ADC_W'($urandom_range(1, 20));
      3: return gscs_pkg::ADC_W'($urandom_range(1000, 1023));
      default: return gscs_pkg::ADC_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push(logic rt, logic [gscs_pkg::CH_W-1:0] ch,
      logic [gscs_pkg::ADC_W-1:0] adc);
    pending_samples.push_back('{rt, ch, adc});
  endtask

  task automatic calib_run(logic [gscs_pkg::CH_W-1:0] ch, int n);
    int k;
    int lo, hi;
    lo = $urandom_range(0, 1023);
    hi = $urandom_range(lo, 1023);
    for (k = 0; k < n; k++)
      push(gscs_pkg::REQ_CALIB, ch, gscs_pkg::ADC_W'($urandom_range(lo, hi)));
  endtask

  initial begin
    int i, p;
    logic [gscs_pkg::RATIO_W-1:0] rv;
    error_count = 0;
    result_count = 0;
    calib_done_count = 0;
    sample_count = 0;
    for (i = 0; i < gscs_pkg::RATIO_REGS; i++) ratio_m[i] = gscs_pkg::RATIO_RESET;
    mask_m = '0;
    for (i = 0; i < gscs_pkg::NUM_CHANNELS_DEF; i++) begin
      acc_m[i] = '0;
      cnt_m[i] = '0;
      base_m[i] = 32'h0001_0000;
    end
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.req_type = 1'b0;
    in_req.channel = '0;
    in_req.adc_sample = '0;
    out_res.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // inactive channels first, then defaults on the reset baseline
    push(gscs_pkg::REQ_MEASURE, 2'd0, 10'd512);
    push(gscs_pkg::REQ_CALIB, 2'd3, 10'd100);
    wait_drained();
    write_reg(gscs_pkg::IDX_MASK, 16'hF);
    push(gscs_pkg::REQ_MEASURE, 2'd0, 10'd0);
    push(gscs_pkg::REQ_MEASURE, 2'd1, gscs_pkg::ADC_FULL);
    push(gscs_pkg::REQ_MEASURE, 2'd2, 10'd1);
    push(gscs_pkg::REQ_MEASURE, 2'd3, 10'd511);
    push(gscs_pkg::REQ_MEASURE, 2'd0, 10'd1000);
    push(gscs_pkg::REQ_MEASURE, 2'd1, 10'd93);
    // all-zero adc calibration uses the saturated resistance; all-full gives tiny baseline
    for (i = 0; i < 50; i++) push(gscs_pkg::REQ_CALIB, 2'd0, 10'd0);
    for (i = 0; i < 50; i++) push(gscs_pkg::REQ_CALIB, 2'd1, gscs_pkg::ADC_FULL);
    push(gscs_pkg::REQ_MEASURE, 2'd0, 10'd0);
    push(gscs_pkg::REQ_MEASURE, 2'd1, 10'd700);
    wait_drained();
    // low and full-scale ratio writes, a write to an unused index and a zero baseline
    write_reg(3'd0, 16'd0);
    write_reg(3'd1, 16'd257);
    write_reg(3'd2, 16'd258);
    write_reg(3'd3, 16'hFFFF);
    write_reg(3'd5, 16'h1234);
    for (i = 0; i < 50; i++) push(gscs_pkg::REQ_CALIB, 2'd3, gscs_pkg::ADC_FULL);
    push(gscs_pkg::REQ_MEASURE, 2'd3, 10'd500);
    push(gscs_pkg::REQ_MEASURE, 2'd1, 10'd300);
    push(gscs_pkg::REQ_MEASURE, 2'd2, 10'd300);
    wait_drained();
    write_reg(gscs_pkg::IDX_MASK, 16'h5);
    push(gscs_pkg::REQ_MEASURE, 2'd1, 10'd300);
    push(gscs_pkg::REQ_CALIB, 2'd3, 10'd300);
    push(gscs_pkg::REQ_MEASURE, 2'd2, 10'd300);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      for (i = 0; i < gscs_pkg::RATIO_REGS; i++) begin
        case ($urandom_range(0, 4))
          0: rv = 16'($urandom_range(0, 300));
          1: rv = 16'hFFFF;
          2: rv = 16'($urandom_range(259, 65535));
          default: rv = 16'($urandom_range(300, 4000));
        endcase
        write_reg(3'(i), rv);
      end
      write_reg(gscs_pkg::IDX_MASK,
                (p == 0) ? 16'hF : 16'($urandom_range(0, 15)) | 16'h8);
      while (pending_samples.size() < 110) begin
        if ($urandom_range(0, 3) == 0)
          calib_run(2'($urandom_range(0, 3)), $urandom_range(40, 50));
        else
          push(logic'($urandom_range(0, 4) == 0), 2'($urandom_range(0, 3)), rand_adc());
      end
      wait_drained();
    end
    $display("covered %0d requests, %0d results, %0d completed calibrations",
             sample_count, result_count, calib_done_count);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== gas_sensor_calibrate_and_score.f =====
sv/gscs_pkg.sv
sv/gscs_if.sv
sv/gscs_div.sv
sv/gscs_mem.sv
sv/gas_sensor_calibrate_and_score.sv
sim/gas_sensor_calibrate_and_score_tb.sv
